// ===== rtl/tga_rle_pkg.sv =====
package tga_rle_pkg;

    localparam int MAX_PIXEL_BYTES = 4;

    localparam int PIX_W   = 8 * MAX_PIXEL_BYTES;
    localparam int BPP_W   = 3;
    localparam int TOTAL_W = 32;

    // Register byte addresses on the APB port: index in paddr[3:2].
    localparam int       ADDR_W    = 4;
    localparam bit [1:0] REG_WIDTH  = 2'd0;
    localparam bit [1:0] REG_HEIGHT = 2'd1;
    localparam bit [1:0] REG_BPP    = 2'd2;

    localparam bit [7:0] RUN_FLAG_MIN = 8'd128;
    localparam bit [7:0] RUN_BIAS     = 8'd127;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PIXEL   = 3'b010,
        PH_STOPPED = 3'b100
    } t_phase;

    // Settings as the decoder sees them, already clamped to their valid ranges.
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [BPP_W-1:0]   bpp;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic [7:0]       repeat_count;
        logic             image_done;
        logic             overflow;
    } t_result;

endpackage

// ===== rtl/tga_rle_decoder_core.sv =====
// TGA run-length pixel decoder: one compressed byte per word on the slave stream, one
// word per cycle while the output buffer has space. The pixel word of a byte is held in the
// input register and then in the output buffer before it is offered on the master stream.
// A byte is held in the input register, is decoded in a single pass, and its result
// goes into a two-entry output buffer, so input and output stalls are decoupled. Literal
// pixels come out with repeat count 1; a run pixel comes out once with its count. tlast
// marks the word that completes width*height pixels; tuser flags a packet that ran past
// that end. Bytes after the image end are dropped until a word with the start flag.
// Width, height and bytes per pixel are set over APB; the user must do so while the stream is idle (not enforced).
module tga_rle_decoder_core
    import tga_rle_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tga_rle_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // data_byte
    input  logic                       s_axis_tuser,   // start_req
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [39:0]                m_axis_tdata,   // pixel_value, repeat_count
    output logic                       m_axis_tlast,   // image_done
    output logic                       m_axis_tuser    // overflow
);

    t_cfg    w_cfg;
    logic    w_space;
    logic    w_push;
    t_result w_res;
    t_result w_out;

    tga_rle_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tga_rle_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_start     (s_axis_tuser),
        .i_cfg       (w_cfg),
        .i_res_space (w_space),
        .o_res_push  (w_push),
        .o_res       (w_res)
    );

    tga_rle_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_space (w_space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {w_out.repeat_count, w_out.pixel_value};
    assign m_axis_tlast = w_out.image_done;
    assign m_axis_tuser = w_out.overflow;

endmodule

// ===== rtl/tga_rle_regs.sv =====
module tga_rle_regs
    import tga_rle_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tga_rle_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    logic [15:0]      r_width;
    logic [15:0]      r_height;
    logic [BPP_W-1:0] r_bpp;
    logic [31:0]      r_total;

    logic [15:0]      w_eff_w;
    logic [15:0]      w_eff_h;
    logic [BPP_W-1:0] w_eff_bpp;
    logic [1:0]       w_index;
    logic             w_wr;

    assign pready  = 1'b1;
    assign w_index = paddr[3:2];
    assign w_wr    = psel && penable && pwrite;

    // A zero dimension counts as one pixel.
    assign w_eff_w = (r_width == 16'd0) ? 16'd1 : r_width;
    assign w_eff_h = (r_height == 16'd0) ? 16'd1 : r_height;

    always_comb begin
        if (r_bpp == '0) begin
            w_eff_bpp = BPP_W'(1);
        end else if (r_bpp > BPP_W'(MAX_PIXEL_BYTES)) begin
            w_eff_bpp = BPP_W'(MAX_PIXEL_BYTES);
        end else begin
            w_eff_bpp = r_bpp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 16'd1;
            r_height <= 16'd1;
            r_bpp    <= BPP_W'(3);
            r_total  <= 32'd1;
        end else begin
            if (w_wr && pready) begin
                unique case (w_index)
                    REG_WIDTH:  r_width  <= pwdata[15:0];
                    REG_HEIGHT: r_height <= pwdata[15:0];
                    REG_BPP:    r_bpp    <= pwdata[BPP_W-1:0];
                    default: ;
                endcase
            end
            r_total <= w_eff_w * w_eff_h;
        end
    end

    always_comb begin
        unique case (w_index)
            REG_WIDTH:  prdata = {16'd0, r_width};
            REG_HEIGHT: prdata = {16'd0, r_height};
            REG_BPP:    prdata = {{(32-BPP_W){1'b0}}, r_bpp};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg.total = r_total;
    assign o_cfg.bpp   = w_eff_bpp;

endmodule

// ===== rtl/tga_rle_decode.sv =====
module tga_rle_decode
    import tga_rle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  t_cfg       i_cfg,
    input  logic       i_res_space,
    output logic       o_res_push,
    output t_result    o_res
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_start;

    t_phase           r_phase,  n_phase;
    logic [7:0]       r_left,   n_left;
    logic             r_run,    n_run;
    logic [1:0]       r_bip,    n_bip;
    logic [PIX_W-1:0] r_gather, n_gather;
    logic [31:0]      r_done,   n_done;

    logic             w_fire;
    t_phase           w_ph;
    logic [7:0]       w_left;
    logic             w_run;
    logic [1:0]       w_bip;
    logic [PIX_W-1:0] w_gather;
    logic [31:0]      w_done_cnt;
    logic [31:0]      w_remaining;
    logic             w_finished;
    logic [PIX_W-1:0] w_gather_new;
    logic             w_last_byte;
    logic             w_run_ovf;
    logic [7:0]       w_run_count;
    logic [7:0]       w_left_dec;
    logic             w_push;
    t_result          w_res;

    assign w_fire     = r_in_valid && i_res_space;
    assign o_in_ready = !r_in_valid || i_res_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_byte;
            r_in_start <= i_start;
        end
    end

    // A start word clears the decoder before its own byte is looked at.
    assign w_ph       = r_in_start ? PH_HEADER : r_phase;
    assign w_left     = r_in_start ? 8'd0 : r_left;
    assign w_run      = r_in_start ? 1'b0 : r_run;
    assign w_bip      = r_in_start ? 2'd0 : r_bip;
    assign w_gather   = r_in_start ? '0 : r_gather;
    assign w_done_cnt = r_in_start ? 32'd0 : r_done;

    assign w_finished   = w_done_cnt >= i_cfg.total;
    assign w_remaining  = i_cfg.total - w_done_cnt;
    assign w_gather_new = w_gather | (PIX_W'(r_in_byte) << {w_bip, 3'b000});
    assign w_last_byte  = ({1'b0, w_bip} + 3'd1) >= i_cfg.bpp;
    assign w_run_ovf    = {24'd0, w_left} > w_remaining;
    assign w_run_count  = w_run_ovf ? w_remaining[7:0] : w_left;
    assign w_left_dec   = w_left - 8'd1;

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_run    = r_run;
        n_bip    = r_bip;
        n_gather = r_gather;
        n_done   = r_done;
        w_push   = 1'b0;
        w_res    = '0;
        if (w_fire) begin
            n_phase  = w_ph;
            n_left   = w_left;
            n_run    = w_run;
            n_bip    = w_bip;
            n_gather = w_gather;
            n_done   = w_done_cnt;
            unique case (w_ph)
                PH_HEADER: begin
                    if (w_finished) begin
                        n_phase = PH_STOPPED;
                    end else begin
                        if (r_in_byte < RUN_FLAG_MIN) begin
                            n_run  = 1'b0;
                            n_left = r_in_byte + 8'd1;
                        end else begin
                            n_run  = 1'b1;
                            n_left = r_in_byte - RUN_BIAS;
                        end
                        n_bip    = 2'd0;
                        n_gather = '0;
                        n_phase  = PH_PIXEL;
                    end
                end
                PH_PIXEL: begin
                    if (w_finished) begin
                        n_phase = PH_STOPPED;
                    end else if (!w_last_byte) begin
                        n_gather = w_gather_new;
                        n_bip    = w_bip + 2'd1;
                    end else begin
                        n_bip             = 2'd0;
                        n_gather          = '0;
                        w_push            = 1'b1;
                        w_res.pixel_value = w_gather_new;
                        if (w_run) begin
                            // One word stands for the whole run, cut at the image end.
                            w_res.repeat_count = w_run_count;
                            w_res.overflow     = w_run_ovf;
                            w_res.image_done   = w_run_ovf || ({24'd0, w_left} == w_remaining);
                            n_done             = w_done_cnt + {24'd0, w_run_count};
                            n_left             = 8'd0;
                            n_phase            = w_res.image_done ? PH_STOPPED : PH_HEADER;
                        end else begin
                            w_res.repeat_count = 8'd1;
                            w_res.image_done   = (w_remaining == 32'd1);
                            w_res.overflow     = w_res.image_done && (w_left_dec != 8'd0);
                            n_done             = w_done_cnt + 32'd1;
                            n_left             = w_left_dec;
                            if (w_res.image_done) begin
                                n_phase = PH_STOPPED;
                            end else if (w_left_dec == 8'd0) begin
                                n_phase = PH_HEADER;
                            end
                        end
                    end
                end
                PH_STOPPED: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_left   <= 8'd0;
            r_run    <= 1'b0;
            r_bip    <= 2'd0;
            r_gather <= '0;
            r_done   <= 32'd0;
        end else begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_run    <= n_run;
            r_bip    <= n_bip;
            r_gather <= n_gather;
            r_done   <= n_done;
        end
    end

    assign o_res_push = w_push;
    assign o_res      = w_res;

    a_push_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (o_res.repeat_count != 8'd0))
        else $error("decoded word with zero repeat count");

    a_overflow_ends_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.overflow) |-> o_res.image_done)
        else $error("overflow flagged on a word that does not end the image");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.image_done) |=> (r_phase == PH_STOPPED))
        else $error("decoder still running after the last pixel");

    a_push_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> i_res_space)
        else $error("word pushed into a full output buffer");

endmodule

// ===== rtl/tga_rle_out_buf.sv =====
module tga_rle_out_buf
    import tga_rle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign o_valid = r_count != 2'd0;
    assign o_space = r_count != 2'd2;
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule
